FILE: hw/rtl/obb_pkg.sv
package obb_pkg;

  localparam int COORD_BITS = 16;
  localparam int QFRAC      = 14;
  localparam int QUAT_BITS  = QFRAC + 2;
  localparam int ENT_BITS   = QUAT_BITS;
  localparam int TOL_BITS   = 16;

  localparam int CENTER_BITS = 3 * COORD_BITS;
  localparam int ROT_BITS    = 4 * QUAT_BITS;

  // entry x entry product and its rounded result
  localparam int EE_P_BITS = 2 * ENT_BITS + 1;
  localparam int MQ_BITS   = EE_P_BITS - QFRAC;
  localparam int SUM_BITS  = MQ_BITS + 3;
  localparam int DOT_BITS  = MQ_BITS + 2;

  // center difference and its projection
  localparam int D_BITS    = COORD_BITS + 1;
  localparam int DE_P_BITS = D_BITS + ENT_BITS;
  localparam int CT_BITS   = DE_P_BITS - QFRAC;
  localparam int TSUM_BITS = CT_BITS + 2;

  // size x dot product and the radius sum over six terms
  localparam int SD_P_BITS = COORD_BITS + 1 + DOT_BITS;
  localparam int RT_BITS   = SD_P_BITS - QFRAC;
  localparam int RAD_BITS  = RT_BITS + 3;

  localparam int NCROSS = 9;
  localparam int NAXES  = 6 + NCROSS;
  localparam int NSTAGE = 7;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(16);
  localparam int ROUND_HALF = 1 << (QFRAC - 1);

  localparam logic signed [SUM_BITS-1:0] Q_ONE_S  = SUM_BITS'(1 << QFRAC);
  localparam logic signed [SUM_BITS-1:0] SAT_HI_S = SUM_BITS'((1 << (ENT_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO_S = SUM_BITS'(-(1 << (ENT_BITS - 1)));

  typedef logic signed [ENT_BITS-1:0] ent_t;
  typedef logic signed [MQ_BITS-1:0]  mq_t;
  typedef ent_t vec3_t [3];
  typedef ent_t mat_t [3][3];
  typedef logic [COORD_BITS-1:0] size3_t [3];
  typedef logic signed [D_BITS-1:0] dvec_t [3];
  typedef logic [NSTAGE-1:0] stage_en_t;

  // round(a*b / 2^q), ties up
  function automatic mq_t mulq_ee(input ent_t a, input ent_t b);
    logic signed [EE_P_BITS-1:0] p;
    p = a * b;
    p = p + EE_P_BITS'(ROUND_HALF);
    return MQ_BITS'(p >>> QFRAC);
  endfunction

  function automatic logic signed [CT_BITS-1:0] mulq_de(input logic signed [D_BITS-1:0] a,
                                                       input ent_t b);
    logic signed [DE_P_BITS-1:0] p;
    p = a * b;
    p = p + DE_P_BITS'(ROUND_HALF);
    return CT_BITS'(p >>> QFRAC);
  endfunction

  function automatic logic signed [RT_BITS-1:0] mulq_sd(input logic [COORD_BITS-1:0] s,
                                                       input logic signed [DOT_BITS-1:0] dt);
    logic signed [SD_P_BITS-1:0] p;
    p = $signed({1'b0, s}) * dt;
    p = p + SD_P_BITS'(ROUND_HALF);
    return RT_BITS'(p >>> QFRAC);
  endfunction

  function automatic ent_t sat_ent(input logic signed [SUM_BITS-1:0] v);
    ent_t r;
    if (v > SAT_HI_S) r = ENT_BITS'(SAT_HI_S);
    else if (v < SAT_LO_S) r = ENT_BITS'(SAT_LO_S);
    else r = ENT_BITS'(v);
    return r;
  endfunction

  function automatic logic [ENT_BITS-1:0] abs_ent(input ent_t a);
    logic signed [ENT_BITS:0] e;
    e = a;
    if (e < 0) e = -e;
    return ENT_BITS'(e);
  endfunction

endpackage

FILE: hw/rtl/obb_in_if.sv
interface obb_in_if;
  import obb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CENTER_BITS-1:0] first_center;
  logic [CENTER_BITS-1:0] first_size;
  logic [ROT_BITS-1:0]    first_rotation;
  logic [CENTER_BITS-1:0] second_center;
  logic [CENTER_BITS-1:0] second_size;
  logic [ROT_BITS-1:0]    second_rotation;

  modport source (output valid, first_center, first_size, first_rotation,
                  second_center, second_size, second_rotation, input ready);
  modport sink (input valid, first_center, first_size, first_rotation,
                second_center, second_size, second_rotation, output ready);
endinterface

FILE: hw/rtl/obb_out_if.sv
interface obb_out_if;
  logic valid;
  logic ready;
  logic boxes_overlap;

  modport source (output valid, boxes_overlap, input ready);
  modport sink (input valid, boxes_overlap, output ready);
endinterface

FILE: hw/rtl/obb_quat_matrix.sv
module obb_quat_matrix (
  input  logic                             clk,
  input  obb_pkg::stage_en_t               en,
  input  logic [obb_pkg::ROT_BITS-1:0]     rotation,
  output obb_pkg::mat_t                    mat_r
);
  import obb_pkg::*;

  ent_t w, x, y, z;
  mq_t  xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  mat_t mat_nxt;

  assign w = rotation[QUAT_BITS-1:0];
  assign x = rotation[2*QUAT_BITS-1:QUAT_BITS];
  assign y = rotation[3*QUAT_BITS-1:2*QUAT_BITS];
  assign z = rotation[4*QUAT_BITS-1:3*QUAT_BITS];

  // quaternion products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xx_r <= mulq_ee(x, x);
      yy_r <= mulq_ee(y, y);
      zz_r <= mulq_ee(z, z);
      xy_r <= mulq_ee(x, y);
      xz_r <= mulq_ee(x, z);
      yz_r <= mulq_ee(y, z);
      wx_r <= mulq_ee(w, x);
      wy_r <= mulq_ee(w, y);
      wz_r <= mulq_ee(w, z);
    end
  end

  always_comb begin
    mat_nxt[0][0] = sat_ent(Q_ONE_S - ((SUM_BITS'(yy_r) + SUM_BITS'(zz_r)) <<< 1));
    mat_nxt[0][1] = sat_ent((SUM_BITS'(xy_r) - SUM_BITS'(wz_r)) <<< 1);
    mat_nxt[0][2] = sat_ent((SUM_BITS'(xz_r) + SUM_BITS'(wy_r)) <<< 1);
    mat_nxt[1][0] = sat_ent((SUM_BITS'(xy_r) + SUM_BITS'(wz_r)) <<< 1);
    mat_nxt[1][1] = sat_ent(Q_ONE_S - ((SUM_BITS'(xx_r) + SUM_BITS'(zz_r)) <<< 1));
    mat_nxt[1][2] = sat_ent((SUM_BITS'(yz_r) - SUM_BITS'(wx_r)) <<< 1);
    mat_nxt[2][0] = sat_ent((SUM_BITS'(xz_r) - SUM_BITS'(wy_r)) <<< 1);
    mat_nxt[2][1] = sat_ent((SUM_BITS'(yz_r) + SUM_BITS'(wx_r)) <<< 1);
    mat_nxt[2][2] = sat_ent(Q_ONE_S - ((SUM_BITS'(xx_r) + SUM_BITS'(yy_r)) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mat_r <= mat_nxt;
    end
  end
endmodule

FILE: hw/rtl/obb_cross_axes.sv
module obb_cross_axes (
  input  logic                           clk,
  input  obb_pkg::stage_en_t             en,
  input  obb_pkg::mat_t                  ma,
  input  obb_pkg::mat_t                  mb,
  input  logic [obb_pkg::TOL_BITS-1:0]   tol,
  output obb_pkg::vec3_t                 axis_r [obb_pkg::NCROSS],
  output logic [obb_pkg::NCROSS-1:0]     skip_r
);
  import obb_pkg::*;

  vec3_t                axis_nxt [NCROSS];
  logic  [NCROSS-1:0]   skip_nxt;

  // a_i x b_j for every pair of basis vectors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        axis_nxt[3*i+j][0] = sat_ent(SUM_BITS'(mulq_ee(ma[1][i], mb[2][j]))
                                   - SUM_BITS'(mulq_ee(ma[2][i], mb[1][j])));
        axis_nxt[3*i+j][1] = sat_ent(SUM_BITS'(mulq_ee(ma[2][i], mb[0][j]))
                                   - SUM_BITS'(mulq_ee(ma[0][i], mb[2][j])));
        axis_nxt[3*i+j][2] = sat_ent(SUM_BITS'(mulq_ee(ma[0][i], mb[1][j]))
                                   - SUM_BITS'(mulq_ee(ma[1][i], mb[0][j])));
        skip_nxt[3*i+j] = (abs_ent(axis_nxt[3*i+j][0]) < tol)
                        && (abs_ent(axis_nxt[3*i+j][1]) < tol)
                        && (abs_ent(axis_nxt[3*i+j][2]) < tol);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      axis_r <= axis_nxt;
      skip_r <= skip_nxt;
    end
  end
endmodule

FILE: hw/rtl/obb_axis_project.sv
module obb_axis_project (
  input  logic                clk,
  input  obb_pkg::stage_en_t  en,
  input  obb_pkg::vec3_t      axis,
  input  logic                skip,
  input  obb_pkg::mat_t       ma,
  input  obb_pkg::mat_t       mb,
  input  obb_pkg::size3_t     sa,
  input  obb_pkg::size3_t     sb,
  input  obb_pkg::dvec_t      d,
  output logic                sep_r
);
  import obb_pkg::*;

  mq_t                         pa_r [3][3];
  mq_t                         pb_r [3][3];
  logic signed [CT_BITS-1:0]   pc_r [3];
  size3_t                      sa_r, sb_r;
  logic                        skip3_r, skip4_r;

  logic signed [RT_BITS-1:0]   ra_r [3];
  logic signed [RT_BITS-1:0]   rb_r [3];
  logic signed [TSUM_BITS-1:0] t_r;

  logic signed [DOT_BITS-1:0]  dot_a [3];
  logic signed [DOT_BITS-1:0]  dot_b [3];
  logic signed [TSUM_BITS-1:0] t_nxt;
  logic [RAD_BITS-1:0]         rad;
  logic [RAD_BITS-1:0]         twice_t;
  logic                        sep_nxt;

  // per-component products against the axis
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pa_r[k][i] <= mulq_ee(ma[k][i], axis[k]);
          pb_r[k][i] <= mulq_ee(mb[k][i], axis[k]);
        end
        pc_r[k] <= mulq_de(d[k], axis[k]);
      end
      sa_r    <= sa;
      sb_r    <= sb;
      skip3_r <= skip;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot_a[i] = DOT_BITS'(pa_r[0][i]) + DOT_BITS'(pa_r[1][i]) + DOT_BITS'(pa_r[2][i]);
      dot_b[i] = DOT_BITS'(pb_r[0][i]) + DOT_BITS'(pb_r[1][i]) + DOT_BITS'(pb_r[2][i]);
    end
    t_nxt = TSUM_BITS'(pc_r[0]) + TSUM_BITS'(pc_r[1]) + TSUM_BITS'(pc_r[2]);
  end

  // full-size scaled projections
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        ra_r[i] <= mulq_sd(sa_r[i], dot_a[i]);
        rb_r[i] <= mulq_sd(sb_r[i], dot_b[i]);
      end
      t_r     <= t_nxt;
      skip4_r <= skip3_r;
    end
  end

  always_comb begin
    logic signed [RT_BITS:0]   ea;
    logic signed [RT_BITS:0]   eb;
    logic signed [TSUM_BITS:0] et;
    rad = '0;
    for (int i = 0; i < 3; i++) begin
      ea = ra_r[i];
      eb = rb_r[i];
      if (ea < 0) ea = -ea;
      if (eb < 0) eb = -eb;
      rad = rad + RAD_BITS'(ea) + RAD_BITS'(eb);
    end
    et = t_r;
    if (et < 0) et = -et;
    twice_t = RAD_BITS'(et) << 1;
    sep_nxt = !skip4_r && (twice_t > rad);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sep_r <= sep_nxt;
    end
  end
endmodule

FILE: hw/rtl/oriented_box_overlap_test_unit.sv
// Oriented box overlap test by separating axes. Each input beat carries two
// boxes (center, full edge sizes, unit quaternion); one result beat per input
// beat answers whether they overlap. Fully pipelined: a new box pair is taken
// every cycle unless a stalled output has filled the pipeline. The seven
// stages are quaternion products, matrix assembly, cross axes, axis
// projections, radius terms, axis compare and the output register.
// Back-pressure is handled stage by stage, so empty stages keep filling while
// the output waits, and nothing is lost or repeated. cfg_wr_data sets the
// parallel tolerance (reset 16, unsigned Q2.14) below which a cross axis is skipped;
// write it only while the pipeline is empty.
module oriented_box_overlap_test_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  obb_in_if.sink                        in_beat,
  obb_out_if.source                     out_beat,
  input  logic                          cfg_wr_en,
  input  logic [obb_pkg::TOL_BITS-1:0]  cfg_wr_data
);
  import obb_pkg::*;

  // pipeline control: a stage may load when it is empty or the next one loads
  logic [NSTAGE-1:0] v_r, v_nxt;
  stage_en_t         en;

  logic [TOL_BITS-1:0] tol_r;

  // payload carried alongside the matrix and cross stages
  dvec_t  d_nxt, d_s0_r, d_s1_r, d_s2_r;
  size3_t sa_nxt, sb_nxt;
  size3_t sa_s0_r, sa_s1_r, sa_s2_r;
  size3_t sb_s0_r, sb_s1_r, sb_s2_r;

  mat_t ma_s1, mb_s1;
  mat_t ma_s2_r, mb_s2_r;

  vec3_t              cross_axis [NCROSS];
  logic [NCROSS-1:0]  cross_skip;

  vec3_t             axis_all [NAXES];
  logic [NAXES-1:0]  skip_all;
  logic [NAXES-1:0]  sep;

  logic overlap_r;

  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_beat.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_beat.valid : v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_beat.ready = en[0];

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // unpack centers and sizes, x in the low bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = D_BITS'($signed(in_beat.second_center[k*COORD_BITS +: COORD_BITS]))
               - D_BITS'($signed(in_beat.first_center[k*COORD_BITS +: COORD_BITS]));
      sa_nxt[k] = in_beat.first_size[k*COORD_BITS +: COORD_BITS];
      sb_nxt[k] = in_beat.second_size[k*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_s0_r  <= d_nxt;
      sa_s0_r <= sa_nxt;
      sb_s0_r <= sb_nxt;
    end
    if (en[1]) begin
      d_s1_r  <= d_s0_r;
      sa_s1_r <= sa_s0_r;
      sb_s1_r <= sb_s0_r;
    end
    if (en[2]) begin
      d_s2_r  <= d_s1_r;
      sa_s2_r <= sa_s1_r;
      sb_s2_r <= sb_s1_r;
      ma_s2_r <= ma_s1;
      mb_s2_r <= mb_s1;
    end
  end

  // rotation matrices, columns are the box axes
  obb_quat_matrix u_mat_a (
    .clk      (clk),
    .en       (en),
    .rotation (in_beat.first_rotation),
    .mat_r    (ma_s1)
  );

  obb_quat_matrix u_mat_b (
    .clk      (clk),
    .en       (en),
    .rotation (in_beat.second_rotation),
    .mat_r    (mb_s1)
  );

  // edge-edge axes, one per pair of basis vectors, with their near-parallel flags
  obb_cross_axes u_cross (
    .clk    (clk),
    .en     (en),
    .ma     (ma_s1),
    .mb     (mb_s1),
    .tol    (tol_r),
    .axis_r (cross_axis),
    .skip_r (cross_skip)
  );

  // axis list: face normals of a and b interleaved, then the cross axes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        axis_all[2*i][k]   = ma_s2_r[k][i];
        axis_all[2*i+1][k] = mb_s2_r[k][i];
      end
      skip_all[2*i]   = 1'b0;
      skip_all[2*i+1] = 1'b0;
    end
    for (int c = 0; c < NCROSS; c++) begin
      axis_all[6+c] = cross_axis[c];
      skip_all[6+c] = cross_skip[c];
    end
  end

  // one projection lane per candidate axis
  for (genvar g = 0; g < NAXES; g++) begin : g_axis
    obb_axis_project u_proj (
      .clk   (clk),
      .en    (en),
      .axis  (axis_all[g]),
      .skip  (skip_all[g]),
      .ma    (ma_s2_r),
      .mb    (mb_s2_r),
      .sa    (sa_s2_r),
      .sb    (sb_s2_r),
      .d     (d_s2_r),
      .sep_r (sep[g])
    );
  end

  // overlap when no lane found a separating axis
  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      overlap_r <= ~|sep;
    end
  end

  assign out_beat.valid         = v_r[NSTAGE-1];
  assign out_beat.boxes_overlap = overlap_r;

`ifndef SYNTHESIS
  // an accepted beat lands in the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && in_beat.ready) |=> v_r[0])
    else $error("accepted beat missing from first stage");

  // a blocked next-to-last stage keeps its beat
  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (!en[NSTAGE-2] && v_r[NSTAGE-2]) |=> v_r[NSTAGE-2])
    else $error("stalled stage dropped its beat");

  // full pipeline with a stalled output takes nothing new
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_beat.ready) |-> !in_beat.ready)
    else $error("input taken while pipeline full and output stalled");
`endif
endmodule
